>>> rtl/core/lmfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfe_pkg
// Shared types, codes and the gamma table of the LED matrix frame encoder.
// ----------------------------------------------------------------------------
package lmfe_pkg;

	localparam int PANEL_WIDTH      = 13;
	localparam int PANEL_HEIGHT     = 9;
	localparam int BRIGHTNESS_SCALE = 32;

	// coordinate math width: holds 2 * panel width for the full panel range
	localparam int COORD_W = 8;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	localparam logic [1:0] SLOT_GREEN = 2'd0;
	localparam logic [1:0] SLOT_RED   = 2'd1;
	localparam logic [1:0] SLOT_BLUE  = 2'd2;

	localparam logic [1:0] ORIENT_MIRROR = 2'd1;
	localparam logic [1:0] ORIENT_ROTATE = 2'd2;

	typedef struct packed {
		logic       action;
		logic [4:0] column;
		logic [3:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic [31:0] spi_code;
		logic [7:0]  led_position;
		logic [1:0]  colour_slot;
		logic        last_of_led;
		logic        last_of_frame;
	} result_t;

	typedef struct packed {
		logic       clr;
		logic       capture;
		logic       wr;
		logic       emit;
		logic [1:0] slot;
		logic       advance;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
	} status_t;

	typedef logic [7:0] gamma_rom_t [256];

	// round(S * (i/255)^1.2), halves up, exact: smallest u with
	// (2u+1)^5 * 255^6 > 32 * S^5 * i^6, saturated at 255
	function automatic logic [7:0] gamma_entry(int unsigned i);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [127:0] base;
		logic [7:0]   res;
		logic         done;
		rhs  = 128'd32;
		base = 128'd1;
		res  = 8'd255;
		done = 1'b0;
		for (int n = 0; n < 5; n++) rhs = rhs * 128'(BRIGHTNESS_SCALE);
		for (int n = 0; n < 6; n++) rhs = rhs * 128'(i);
		for (int n = 0; n < 6; n++) base = base * 128'd255;
		for (int u = 0; u < 255; u++) begin
			if (!done) begin
				lhs = base;
				for (int n = 0; n < 5; n++) lhs = lhs * 128'(2 * u + 1);
				if (lhs > rhs) begin
					res  = 8'(u);
					done = 1'b1;
				end
			end
		end
		return res;
	endfunction

	function automatic gamma_rom_t build_gamma();
		gamma_rom_t rom;
		for (int i = 0; i < 256; i++) rom[i] = gamma_entry(i);
		return rom;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage
`default_nettype wire

>>> rtl/core/lmfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfe_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lmfe_ram #(
	parameter int Width = 24,
	parameter int Depth = 234
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/lmfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfe_ctrl
// Sequencer: frame clear after reset, pixel write, three-beat fetch.
// ----------------------------------------------------------------------------
module lmfe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              action,
	input  wire lmfe_pkg::status_t sts,
	output lmfe_pkg::cmd_t         cmd,
	output logic                   busy
);
	import lmfe_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_GREEN,
		ST_RED,
		ST_BLUE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (start) begin
						state_q <= (action == ACT_FETCH) ? ST_GREEN : ST_WRITE;
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_GREEN: state_q <= ST_RED;
				ST_RED:   state_q <= ST_BLUE;
				ST_BLUE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.clr     = (state_q == ST_CLEAR);
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.wr      = (state_q == ST_WRITE);
		cmd.emit    = (state_q == ST_GREEN) || (state_q == ST_RED) || (state_q == ST_BLUE);
		cmd.advance = (state_q == ST_BLUE);
		unique case (state_q)
			ST_RED:  cmd.slot = SLOT_RED;
			ST_BLUE: cmd.slot = SLOT_BLUE;
			default: cmd.slot = SLOT_GREEN;
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_blue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> !busy)
		else $error("fetch did not return to idle after blue beat");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> busy)
		else $error("beat emitted while idle");

endmodule
`default_nettype wire

>>> rtl/core/lmfe_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfe_dpath
// Gamma, chain index, frame RAM, readout pointer and SPI nibble encoding.
// ----------------------------------------------------------------------------
module lmfe_dpath #(
	parameter int PanelWidth  = lmfe_pkg::PANEL_WIDTH,
	parameter int PanelHeight = lmfe_pkg::PANEL_HEIGHT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lmfe_pkg::cmd_t    cmd,
	output lmfe_pkg::status_t      sts,
	input  wire lmfe_pkg::item_t   item,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_data,
	output logic                   strobe,
	output lmfe_pkg::result_t      result
);
	import lmfe_pkg::*;

	localparam int PanelLeds = PanelWidth * PanelHeight;
	localparam int LedTotal  = 2 * PanelLeds;
	localparam int IdxW      = $clog2(LedTotal);

	localparam logic [IdxW-1:0]    LastIdx = IdxW'(LedTotal - 1);
	localparam logic [COORD_W-1:0] XSpan   = COORD_W'(2 * PanelWidth);
	localparam logic [COORD_W-1:0] XPanel  = COORD_W'(PanelWidth);
	localparam logic [COORD_W-1:0] XLast   = COORD_W'(PanelWidth - 1);
	localparam logic [COORD_W-1:0] YSpan   = COORD_W'(PanelHeight);
	localparam logic [COORD_W-1:0] YLast   = COORD_W'(PanelHeight - 1);

	logic [1:0]         orient_q;
	logic [IdxW-1:0]    ptr_q;
	logic [IdxW-1:0]    clr_q;
	item_t              item_s1;
	logic               strobe_q;
	result_t            result_q;

	logic [COORD_W-1:0] colw;
	logic [COORD_W-1:0] roww;
	logic [COORD_W-1:0] xp;
	logic [COORD_W-1:0] yp;
	logic               right;
	logic               in_range;
	logic [IdxW-1:0]    widx;
	logic [23:0]        grb;

	logic               ram_we;
	logic [IdxW-1:0]    ram_waddr;
	logic [23:0]        ram_wdata;
	logic [23:0]        ram_rdata;
	logic [7:0]         byte_sel;
	logic [31:0]        code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= '0;
			ptr_q    <= '0;
			clr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid) orient_q <= cfg_data;
			if (cmd.clr) clr_q <= (clr_q == LastIdx) ? '0 : clr_q + 1'b1;
			if (cmd.advance) ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_s1 <= item;
	end

	assign sts.clr_done = (clr_q == LastIdx);

	// map image coordinates to the physical chain index
	always_comb begin
		colw     = {3'b0, item_s1.column};
		roww     = {4'b0, item_s1.row};
		in_range = (colw < XSpan) && (roww < YSpan);
		right    = (colw >= XPanel);
		xp       = right ? colw - XPanel : colw;
		yp       = YLast - roww;
		if (right && orient_q == ORIENT_ROTATE) begin
			xp = XLast - xp;
			yp = YLast - yp;
		end else if (right && orient_q == ORIENT_MIRROR) begin
			xp = XLast - xp;
		end
		// odd rows run right to left
		if (yp[0]) xp = XLast - xp;
		widx = (right ? IdxW'(PanelLeds) : '0) + IdxW'(yp) * IdxW'(PanelWidth) + IdxW'(xp);
		grb  = {GAMMA_ROM[item_s1.green], GAMMA_ROM[item_s1.red], GAMMA_ROM[item_s1.blue]};
	end

	assign ram_we    = cmd.clr || (cmd.wr && in_range);
	assign ram_waddr = cmd.clr ? clr_q : widx;
	assign ram_wdata = cmd.clr ? '0 : grb;

	lmfe_ram #(
		.Width (24),
		.Depth (LedTotal)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		unique case (cmd.slot)
			SLOT_GREEN: byte_sel = ram_rdata[23:16];
			SLOT_RED:   byte_sel = ram_rdata[15:8];
			default:    byte_sel = ram_rdata[7:0];
		endcase
		for (int k = 0; k < 8; k++) begin
			code[4*k +: 4] = byte_sel[k] ? 4'hE : 4'h8;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.spi_code      <= code;
			result_q.led_position  <= 8'(ptr_q);
			result_q.colour_slot   <= cmd.slot;
			result_q.last_of_led   <= (cmd.slot == SLOT_BLUE);
			result_q.last_of_frame <= (cmd.slot == SLOT_BLUE) && (ptr_q == LastIdx);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_slot_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.colour_slot != SLOT_GREEN |-> $past(strobe_q))
		else $error("red or blue beat without a preceding beat");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr <= LastIdx)
		else $error("frame write beyond the chain");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last_of_frame |-> ptr_q == '0)
		else $error("readout pointer did not wrap after the last LED");

endmodule
`default_nettype wire

>>> rtl/core/led_matrix_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_frame_encoder: pixel store and SPI-coded readout for two panels
// Write: busy while the captured pixel is written to the frame RAM; pixel
// visible to fetches accepted once busy drops.
// Fetch: three result beats on consecutive cycles, one per colour slot state
// (green, red, blue), each registered after its state; then back to idle.
// Reset: control cleared, then a clear of all 2*PanelWidth*PanelHeight frame
// RAM LEDs (234 by default) with busy high; results are never stalled.
// ----------------------------------------------------------------------------
module led_matrix_frame_encoder #(
	parameter int PanelWidth  = lmfe_pkg::PANEL_WIDTH,
	parameter int PanelHeight = lmfe_pkg::PANEL_HEIGHT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lmfe_pkg::item_t   item,
	output logic                   strobe,
	output lmfe_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_data
);
	import lmfe_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	lmfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lmfe_dpath #(
		.PanelWidth  (PanelWidth),
		.PanelHeight (PanelHeight)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result)
	);

endmodule
`default_nettype wire

>>> sim/lmfe_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfe_frame_checker
// Watches the item, config and result channels of the LED matrix frame
// encoder, keeps its own gamma table, frame store and readout pointer, and
// compares every result beat field by field with the predicted SPI codes.
// ----------------------------------------------------------------------------
module lmfe_frame_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire lmfe_pkg::item_t   item,
	input  wire logic              strobe,
	input  wire lmfe_pkg::result_t result,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [1:0]        cfg_data,
	output int                     mismatches,
	output int                     pending
);
	import lmfe_pkg::*;

	localparam int SIDE_LEDS  = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int CHAIN_LEDS = 2 * SIDE_LEDS;
	localparam int REPORT_MAX = 10;

	localparam logic [3:0] NIBBLE_ONE  = 4'b1110;
	localparam logic [3:0] NIBBLE_ZERO = 4'b1000;

	logic [7:0]  gamma_lut [256];
	logic [23:0] frame_grb [CHAIN_LEDS];
	int unsigned next_led;
	logic [1:0]  orientation;
	result_t     codes_due [$];

	// smallest level whose upper rounding edge lies above the exact curve:
	// (2*lvl+1)^5 * 255^6 > 32 * S^5 * code^6
	function automatic logic [7:0] gamma_level(int unsigned code);
		logic [127:0] target;
		logic [127:0] full6;
		logic [127:0] probe;
		int unsigned  lvl;
		target = 128'd32;
		full6  = 128'd1;
		for (int k = 0; k < 5; k++) target = target * 128'(BRIGHTNESS_SCALE);
		for (int k = 0; k < 6; k++) target = target * 128'(code);
		for (int k = 0; k < 6; k++) full6 = full6 * 128'd255;
		lvl = 0;
		while (lvl < 255) begin
			probe = full6;
			for (int k = 0; k < 5; k++) probe = probe * 128'(2 * lvl + 1);
			if (probe > target) break;
			lvl++;
		end
		return 8'(lvl);
	endfunction

	function automatic int unsigned chain_slot(int unsigned col, int unsigned ybot);
		int unsigned on_right;
		int unsigned x;
		int unsigned y;
		on_right = (col >= PANEL_WIDTH) ? 1 : 0;
		x = on_right ? col - PANEL_WIDTH : col;
		y = ybot;
		if (on_right && orientation == ORIENT_ROTATE) begin
			x = PANEL_WIDTH - 1 - x;
			y = PANEL_HEIGHT - 1 - y;
		end else if (on_right && orientation == ORIENT_MIRROR) begin
			x = PANEL_WIDTH - 1 - x;
		end
		// odd rows run right to left
		if (y % 2 == 1) x = PANEL_WIDTH - 1 - x;
		return on_right * SIDE_LEDS + y * PANEL_WIDTH + x;
	endfunction

	function automatic logic [31:0] spi_nibbles(logic [7:0] colour);
		logic [31:0] code;
		code = '0;
		for (int k = 7; k >= 0; k--) code = {code[27:0], colour[k] ? NIBBLE_ONE : NIBBLE_ZERO};
		return code;
	endfunction

	task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%t lmfe_frame_checker: %s expected %h got %h", $realtime, what, want, got);
	endtask

	task automatic store_pixel(item_t px);
		int unsigned slot;
		if (px.column >= 2 * PANEL_WIDTH || px.row >= PANEL_HEIGHT) return;
		slot = chain_slot(px.column, PANEL_HEIGHT - 1 - px.row);
		frame_grb[slot] = {gamma_lut[px.green], gamma_lut[px.red], gamma_lut[px.blue]};
	endtask

	task automatic predict_led();
		result_t     beat;
		logic [23:0] grb;
		grb = frame_grb[next_led];
		for (int s = 0; s < 3; s++) begin
			beat.spi_code      = spi_nibbles(grb[23 - 8 * s -: 8]);
			beat.led_position  = 8'(next_led);
			beat.colour_slot   = 2'(s);
			beat.last_of_led   = (2'(s) == SLOT_BLUE);
			beat.last_of_frame = (2'(s) == SLOT_BLUE) && (next_led == CHAIN_LEDS - 1);
			codes_due.push_back(beat);
		end
		next_led = (next_led == CHAIN_LEDS - 1) ? 0 : next_led + 1;
	endtask

	initial begin
		mismatches = 0;
		for (int i = 0; i < 256; i++) gamma_lut[i] = gamma_level(i);
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_LEDS; i++) frame_grb[i] = '0;
			next_led    = 0;
			orientation = 2'd0;
			codes_due.delete();
			pending <= 0;
		end else begin
			// retire the beat first: a beat never belongs to an item taken this edge
			if (strobe) begin
				if (codes_due.size() == 0) begin
					flag_field("unexpected beat, spi_code", '0, result.spi_code);
				end else begin
					want = codes_due.pop_front();
					if (result.spi_code !== want.spi_code)
						flag_field("spi_code", want.spi_code, result.spi_code);
					if (result.led_position !== want.led_position)
						flag_field("led_position", want.led_position, result.led_position);
					if (result.colour_slot !== want.colour_slot)
						flag_field("colour_slot", want.colour_slot, result.colour_slot);
					if (result.last_of_led !== want.last_of_led)
						flag_field("last_of_led", want.last_of_led, result.last_of_led);
					if (result.last_of_frame !== want.last_of_frame)
						flag_field("last_of_frame", want.last_of_frame, result.last_of_frame);
				end
			end
			if (cfg_valid && cfg_ready) orientation = cfg_data;
			if (start && !busy) begin
				if (item.action == ACT_FETCH) predict_led();
				else store_pixel(item);
			end
			pending <= codes_due.size();
		end
	end

endmodule
`default_nettype wire

>>> sim/tb_led_matrix_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_led_matrix_frame_encoder
// Drives pixel writes and LED fetches into the frame encoder under several
// right panel orientations, with random idle bursts; the checker beside the
// block predicts every SPI code beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_led_matrix_frame_encoder;
	import lmfe_pkg::*;

	localparam logic [1:0] ORIENT_NORMAL = 2'd0;
	localparam logic [1:0] ORIENT_SPARE  = 2'd3;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 75;
	localparam int FETCH_PCT    = 60;
	localparam int DRAIN_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	item_t      item = '0;
	logic       strobe;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = '0;
	int         mismatch_total;
	int         beats_pending;

	logic [1:0] phase_orient [PHASES] = '{ORIENT_MIRROR, ORIENT_ROTATE, ORIENT_SPARE,
		ORIENT_NORMAL, ORIENT_ROTATE, ORIENT_MIRROR};

	led_matrix_frame_encoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.strobe   (strobe),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	lmfe_frame_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatch_total),
		.pending   (beats_pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_led_matrix_frame_encoder: FAIL");
		$finish;
	end

	// present one item and hold it until the block no longer reports busy
	task automatic issue(item_t it);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic put_pixel(int col, int row, int r, int g, int b);
		item_t it;
		it.action = ACT_WRITE;
		it.column = 5'(col);
		it.row    = 4'(row);
		it.red    = 8'(r);
		it.green  = 8'(g);
		it.blue   = 8'(b);
		issue(it);
	endtask

	function automatic item_t random_item();
		item_t it;
		it.action = ($urandom_range(99) < FETCH_PCT) ? ACT_FETCH : ACT_WRITE;
		// mostly on the panels, now and then off the edge
		it.column = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
			: 5'($urandom_range(2 * PANEL_WIDTH - 1));
		it.row = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
			: 4'($urandom_range(PANEL_HEIGHT - 1));
		it.red   = 8'($urandom);
		it.green = 8'($urandom);
		it.blue  = 8'($urandom);
		return it;
	endfunction

	task automatic fetch_led();
		item_t it;
		it = random_item();
		it.action = ACT_FETCH;
		issue(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_orientation(logic [1:0] mode);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		bit with_gaps;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset orientation: fill the start of the chain and read it back
		put_pixel(0, 8, 255, 0, 128);
		fetch_led();
		put_pixel(1, 8, 1, 254, 127);
		fetch_led();
		// fetch right behind the write of the same LED
		put_pixel(2, 8, 0, 255, 0);
		fetch_led();
		put_pixel(25, 0, 255, 255, 255);
		put_pixel(13, 8, 128, 64, 2);
		put_pixel(12, 0, 200, 100, 50);
		put_pixel(3, 7, 17, 34, 250);
		// off the panels: dropped
		put_pixel(26, 0, 255, 255, 255);
		put_pixel(31, 15, 255, 255, 255);
		put_pixel(0, 9, 255, 255, 255);
		put_pixel(5, 15, 255, 255, 255);
		repeat (3) fetch_led();

		for (int p = 0; p < PHASES; p++) begin
			set_orientation(phase_orient[p]);
			with_gaps = (p != 2) && (p != PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (with_gaps && $urandom_range(3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(15, 1)) @(posedge clk);
				end
				issue(random_item());
			end
		end

		drain();
		if (mismatch_total == 0 && beats_pending == 0) begin
			$display("tb_led_matrix_frame_encoder: PASS");
		end else begin
			$display("tb_led_matrix_frame_encoder: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
